/* hw/rtl/sdts_pkg.sv */
package sdts_pkg;

	localparam int MaxTasks = 16;
	localparam int IdxW = $clog2(MaxTasks);
	localparam int CntW = $clog2(MaxTasks + 1);
	localparam int ResCap = 16;
	localparam int RunW = $clog2(ResCap + 1);

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_ADD = 2'd1,
		ACT_DEL = 2'd2,
		ACT_DISP = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		K_ADDED = 3'd0,
		K_ADD_REF = 3'd1,
		K_DELETED = 3'd2,
		K_DEL_REF = 3'd3,
		K_RUN = 3'd4,
		K_NONE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE = 2'd0,
		E_FULL = 2'd1,
		E_DEL = 2'd2
	} err_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [23:0] delay;
		logic [23:0] period;
		logic [7:0] runs;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DN,
		S_MARK,
		S_AGE,
		S_POP,
		S_OUT
	} state_t;

	// Follow-up after the shift/mark sequence completes.
	typedef enum logic [1:0] {
		NX_DONE,
		NX_RUN,
		NX_REINS
	} next_t;

endpackage

/* hw/rtl/sorted_delay_task_scheduler_core.sv */
// Sorted-delay task scheduler. A tick gives no beat. Add and delete walk the
// table one entry per cycle through a single shared compare/subtract path.
// Dispatch first ages every entry. It then pops each ready head in turn; a
// one-shot task gets its run beat and is dropped, and a periodic one is put
// back. At most 16 run beats leave per dispatch. stall is low only in the
// idle state with the output register empty. Each result beat is held in an
// output register until it is taken. A stalled receiver therefore holds the
// sequencer between run beats.
module sorted_delay_task_scheduler_core (
	input logic clk,
	input logic arst_n,
	input logic valid_in,
	output logic stall_in,
	input logic [1:0] action,
	input logic [15:0] handle_in,
	input logic [23:0] delay_in,
	input logic [23:0] period_in,
	input logic [3:0] slot_in,
	output logic valid_out,
	input logic stall_out,
	output logic [2:0] kind,
	output logic [4:0] slot_out,
	output logic [15:0] handle_out,
	output logic last,
	output logic [4:0] count_out,
	output logic [1:0] error_out
);
	localparam int IW = sdts_pkg::IdxW;
	localparam int CW = sdts_pkg::CntW;

	sdts_pkg::state_t st_q, st_d;
	sdts_pkg::next_t nx_q, nx_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [23:0] ticks_q, ticks_d, snap_q, snap_d;
	logic [1:0] err_q, err_d;
	logic [23:0] head_q, head_d;
	logic [sdts_pkg::RunW-1:0] runs_q, runs_d;
	sdts_pkg::entry_t new_q, new_d;
	sdts_pkg::kind_t okind_q, okind_d;
	logic [4:0] oslot_q, oslot_d;
	logic [15:0] ohand_q, ohand_d;
	logic olast_q, olast_d;
	logic [4:0] ocnt_q, ocnt_d;
	logic [1:0] oerr_q, oerr_d;
	logic ov_q, ov_d;

	logic [IW-1:0] rd_idx, wr_idx, src_idx;
	sdts_pkg::entry_t rd_e, wr_e;
	logic rd_m, wr_en, wr_copy, mark_en, mark_val;

	sdts_table u_table (
		.clk(clk), .arst_n(arst_n),
		.rd_idx(rd_idx), .rd_entry(rd_e), .rd_mark(rd_m),
		.wr_en(wr_en), .wr_idx(wr_idx), .src_idx(src_idx), .wr_copy(wr_copy),
		.wr_entry(wr_e), .mark_en(mark_en), .mark_val(mark_val)
	);

	assign stall_in = (st_q != sdts_pkg::S_IDLE) || ov_q;
	assign valid_out = ov_q;
	assign kind = okind_q;
	assign slot_out = oslot_q;
	assign handle_out = ohand_q;
	assign last = olast_q;
	assign count_out = ocnt_q;
	assign error_out = oerr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sdts_pkg::S_IDLE;
			nx_q <= sdts_pkg::NX_DONE;
			cnt_q <= '0;
			ptr_q <= '0;
			pos_q <= '0;
			ticks_q <= '0;
			snap_q <= '0;
			err_q <= sdts_pkg::E_NONE;
			head_q <= '0;
			runs_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			nx_q <= nx_d;
			cnt_q <= cnt_d;
			ptr_q <= ptr_d;
			pos_q <= pos_d;
			ticks_q <= ticks_d;
			snap_q <= snap_d;
			err_q <= err_d;
			head_q <= head_d;
			runs_q <= runs_d;
			ov_q <= ov_d;
		end
	end

	// Payload registers for the pending entry and the result beat.
	always_ff @(posedge clk) begin
		new_q <= new_d;
		okind_q <= okind_d;
		oslot_q <= oslot_d;
		ohand_q <= ohand_d;
		olast_q <= olast_d;
		ocnt_q <= ocnt_d;
		oerr_q <= oerr_d;
	end

	// Sequencer with one shared compare/subtract path on rd_e.
	always_comb begin
		st_d = st_q; nx_d = nx_q; cnt_d = cnt_q; ptr_d = ptr_q; pos_d = pos_q;
		ticks_d = ticks_q; snap_d = snap_q; err_d = err_q; head_d = head_q;
		runs_d = runs_q; new_d = new_q;
		okind_d = okind_q; oslot_d = oslot_q; ohand_d = ohand_q; olast_d = olast_q;
		ocnt_d = ocnt_q; oerr_d = oerr_q;
		ov_d = ov_q && stall_out;
		rd_idx = ptr_q[IW-1:0];
		wr_idx = ptr_q[IW-1:0];
		src_idx = ptr_q[IW-1:0];
		wr_en = 1'b0; wr_copy = 1'b0; wr_e = rd_e;
		mark_en = 1'b0; mark_val = 1'b0;

		case (st_q)
			sdts_pkg::S_IDLE: begin
				if (valid_in && !ov_q) begin
					rd_idx = '0;
					case (sdts_pkg::action_t'(action))
						sdts_pkg::ACT_TICK: begin
							if (cnt_q != '0) begin
								wr_idx = '0;
								wr_en = 1'b1;
								if (rd_e.delay != '0) wr_e.delay = rd_e.delay - 24'd1;
								if (rd_e.delay <= 24'd1 && rd_e.runs != 8'hFF)
									wr_e.runs = rd_e.runs + 8'd1;
								if (ticks_q != 24'hFFFFFF) ticks_d = ticks_q + 24'd1;
							end
						end
						sdts_pkg::ACT_ADD: begin
							if (cnt_q == CW'(sdts_pkg::MaxTasks)) begin
								err_d = sdts_pkg::E_FULL;
								okind_d = sdts_pkg::K_ADD_REF;
								oslot_d = 5'(sdts_pkg::MaxTasks);
								ohand_d = '0; olast_d = 1'b1;
								ocnt_d = 5'(cnt_q); oerr_d = sdts_pkg::E_FULL;
								ov_d = 1'b1;
							end else begin
								if (cnt_q == '0) ticks_d = '0;
								new_d = '{handle_in, delay_in, period_in, 8'd0};
								nx_d = sdts_pkg::NX_DONE;
								ptr_d = '0;
								st_d = sdts_pkg::S_FIND;
							end
						end
						sdts_pkg::ACT_DEL: begin
							if (CW'(slot_in) >= cnt_q) begin
								err_d = sdts_pkg::E_DEL;
								okind_d = sdts_pkg::K_DEL_REF;
								oslot_d = '0; ohand_d = '0; olast_d = 1'b1;
								ocnt_d = 5'(cnt_q); oerr_d = sdts_pkg::E_DEL;
								ov_d = 1'b1;
							end else begin
								okind_d = sdts_pkg::K_DELETED;
								oslot_d = '0; ohand_d = '0;
								nx_d = sdts_pkg::NX_DONE;
								ptr_d = CW'(slot_in);
								st_d = sdts_pkg::S_SHIFT_DN;
							end
						end
						default: begin
							if (cnt_q == '0 || rd_e.runs == '0) begin
								okind_d = sdts_pkg::K_NONE;
								oslot_d = '0; ohand_d = '0; olast_d = 1'b1;
								ocnt_d = 5'(cnt_q); oerr_d = err_q;
								ov_d = 1'b1;
							end else begin
								snap_d = ticks_q;
								ticks_d = '0;
								runs_d = '0;
								ptr_d = '0;
								st_d = sdts_pkg::S_AGE;
							end
						end
					endcase
				end
			end

			// Age each entry: tied ones become ready, others lose the elapsed ticks.
			sdts_pkg::S_AGE: begin
				wr_en = 1'b1;
				if (rd_m) begin
					wr_e.delay = '0;
					wr_e.runs = 8'd1;
				end else begin
					wr_e.delay = (rd_e.delay >= snap_q) ? rd_e.delay - snap_q : '0;
				end
				if (ptr_q + 1'b1 == cnt_q) begin
					ptr_d = '0;
					st_d = sdts_pkg::S_POP;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end

			// Take the ready head, or end the dispatch with a none beat; the output register is left to the pending beat.
			sdts_pkg::S_POP: begin
				rd_idx = '0;
				if (cnt_q != '0 && rd_e.runs != '0 && 32'(runs_q) < sdts_pkg::ResCap) begin
					new_d = '{rd_e.handle, rd_e.period, rd_e.period, 8'd0};
					nx_d = sdts_pkg::NX_RUN;
					ptr_d = '0;
					st_d = sdts_pkg::S_SHIFT_DN;
				end else if (!ov_q || !stall_out) begin
					okind_d = sdts_pkg::K_NONE;
					oslot_d = '0; ohand_d = '0; olast_d = 1'b1;
					ocnt_d = 5'(cnt_q); oerr_d = err_q;
					ov_d = 1'b1;
					st_d = sdts_pkg::S_IDLE;
				end
			end

			// Close the gap at ptr by copying entries down.
			sdts_pkg::S_SHIFT_DN: begin
				if (ptr_q + 1'b1 < cnt_q) begin
					wr_en = 1'b1; wr_copy = 1'b1;
					src_idx = IW'(ptr_q + 1'b1);
					ptr_d = ptr_q + 1'b1;
				end else begin
					wr_en = 1'b1;
					wr_e = '0;
					mark_en = 1'b1;
					cnt_d = cnt_q - 1'b1;
					ptr_d = '0;
					if (nx_q == sdts_pkg::NX_RUN && new_q.period != '0)
						st_d = sdts_pkg::S_FIND;
					else
						st_d = sdts_pkg::S_MARK;
				end
			end

			// Find the insert index: first entry with a larger delay.
			sdts_pkg::S_FIND: begin
				if (ptr_q == cnt_q || new_q.delay < rd_e.delay) begin
					pos_d = ptr_q;
					ptr_d = cnt_q;
					st_d = sdts_pkg::S_SHIFT_UP;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end

			// Open a hole at pos by copying entries up.
			sdts_pkg::S_SHIFT_UP: begin
				if (ptr_q > pos_q) begin
					wr_en = 1'b1; wr_copy = 1'b1;
					src_idx = IW'(ptr_q - 1'b1);
					ptr_d = ptr_q - 1'b1;
				end else begin
					st_d = sdts_pkg::S_PUT;
				end
			end

			sdts_pkg::S_PUT: begin
				wr_idx = pos_q[IW-1:0];
				wr_en = 1'b1;
				wr_e = new_q;
				cnt_d = cnt_q + 1'b1;
				if (nx_q != sdts_pkg::NX_RUN) begin
					okind_d = sdts_pkg::K_ADDED;
					oslot_d = 5'(pos_q);
					ohand_d = '0;
				end
				ptr_d = '0;
				st_d = sdts_pkg::S_MARK;
			end

			// Recompute tie marks against the head delay.
			sdts_pkg::S_MARK: begin
				if (ptr_q == cnt_q || cnt_q == '0) begin
					if (nx_q == sdts_pkg::NX_RUN) begin
						st_d = sdts_pkg::S_OUT;
					end else begin
						olast_d = 1'b1;
						ocnt_d = 5'(cnt_q); oerr_d = err_q;
						ov_d = 1'b1;
						st_d = sdts_pkg::S_IDLE;
					end
				end else begin
					mark_en = 1'b1;
					mark_val = (rd_e.delay == head_q);
					if (ptr_q == '0) begin
						head_d = rd_e.delay;
						mark_val = 1'b1;
					end
					ptr_d = ptr_q + 1'b1;
				end
			end

			// A run beat: it is the last one unless the new head is ready and the cap allows.
			sdts_pkg::S_OUT: begin
				rd_idx = '0;
				if (!ov_q || !stall_out) begin
					okind_d = sdts_pkg::K_RUN;
					oslot_d = '0;
					ohand_d = new_q.handle;
					ocnt_d = 5'(cnt_q); oerr_d = err_q;
					ov_d = 1'b1;
					runs_d = runs_q + 1'b1;
					if (cnt_q != '0 && rd_e.runs != '0
					    && 32'(runs_q) + 1 < sdts_pkg::ResCap) begin
						olast_d = 1'b0;
						st_d = sdts_pkg::S_POP;
					end else begin
						olast_d = 1'b1;
						st_d = sdts_pkg::S_IDLE;
					end
				end
			end

			default: st_d = sdts_pkg::S_IDLE;
		endcase
	end
endmodule

/* hw/rtl/sdts_table.sv */
// Entry table: one read port for the sequencer, shift moves and single writes.
module sdts_table (
	input logic clk,
	input logic arst_n,
	input logic [sdts_pkg::IdxW-1:0] rd_idx,
	output sdts_pkg::entry_t rd_entry,
	output logic rd_mark,
	input logic wr_en,
	input logic [sdts_pkg::IdxW-1:0] wr_idx,
	input logic [sdts_pkg::IdxW-1:0] src_idx,
	input logic wr_copy,
	input sdts_pkg::entry_t wr_entry,
	input logic mark_en,
	input logic mark_val
);
	sdts_pkg::entry_t ent_q [sdts_pkg::MaxTasks];
	logic mark_q [sdts_pkg::MaxTasks];

	assign rd_entry = ent_q[rd_idx];
	assign rd_mark = mark_q[rd_idx];

	// One entry written per cycle, either a copy from a neighbor or new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sdts_pkg::MaxTasks; i++) begin
				ent_q[i] <= '0;
				mark_q[i] <= 1'b0;
			end
		end else begin
			if (wr_en) begin
				ent_q[wr_idx] <= wr_copy ? ent_q[src_idx] : wr_entry;
			end
			if (mark_en) begin
				mark_q[wr_idx] <= mark_val;
			end
		end
	end
endmodule
